/* rtl/pcb_pkg.sv */
// Shared constants and types for the point cluster box and centroid block.
package pcb_pkg;

	// Number of spatial axes handled per point.
	localparam int NUM_AXES = 3;

	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

endpackage

/* rtl/pcb_point_if.sv */
// Valid/ready channel that carries one cluster point per item.
interface pcb_point_if #(
	parameter int COORD_BITS = 24
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;
	logic                         last_point;

	modport source (
		output valid, coord_x, coord_y, coord_z, last_point,
		input  ready
	);

	modport sink (
		input  valid, coord_x, coord_y, coord_z, last_point,
		output ready
	);
endinterface

/* rtl/pcb_result_if.sv */
// Valid/ready channel that carries one cluster box and centroid per item.
interface pcb_result_if #(
	parameter int COORD_BITS = 24,
	parameter int COUNT_BITS = 17
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] low_x;
	logic signed [COORD_BITS-1:0] low_y;
	logic signed [COORD_BITS-1:0] low_z;
	logic signed [COORD_BITS-1:0] high_x;
	logic signed [COORD_BITS-1:0] high_y;
	logic signed [COORD_BITS-1:0] high_z;
	logic signed [COORD_BITS-1:0] mean_x;
	logic signed [COORD_BITS-1:0] mean_y;
	logic signed [COORD_BITS-1:0] mean_z;
	logic        [COUNT_BITS-1:0] points_seen;
	logic                         overflowed;

	modport source (
		output valid, low_x, low_y, low_z, high_x, high_y, high_z,
		       mean_x, mean_y, mean_z, points_seen, overflowed,
		input  ready
	);

	modport sink (
		input  valid, low_x, low_y, low_z, high_x, high_y, high_z,
		       mean_x, mean_y, mean_z, points_seen, overflowed,
		output ready
	);
endinterface

/* rtl/pcb_accum.sv */
// Running per-axis minimum, maximum and sum plus point count for one cluster.
module pcb_accum #(
	parameter int MAX_POINTS = 65536,
	parameter int COORD_BITS = 24,
	parameter int CNT_W      = 17,
	parameter int SUM_W      = 41
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         clear,
	input  logic                                         take,
	input  logic [pcb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] coord,
	output logic [pcb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] run_min,
	output logic [pcb_pkg::NUM_AXES-1:0][COORD_BITS-1:0] run_max,
	output logic [pcb_pkg::NUM_AXES-1:0][SUM_W-1:0]      run_sum,
	output logic [CNT_W-1:0]                             run_count,
	output logic                                         drop_flag
);
	import pcb_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
	localparam logic [COORD_BITS-1:0] MOST_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [NUM_AXES-1:0][COORD_BITS-1:0] min_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] max_q;
	logic [NUM_AXES-1:0][SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]                    cnt_q;
	logic                                drop_q;
	logic                                full;

	assign full = (cnt_q == MAX_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				min_q[a] <= MOST_POS;
				max_q[a] <= MOST_NEG;
				sum_q[a] <= '0;
			end
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (clear) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				min_q[a] <= MOST_POS;
				max_q[a] <= MOST_NEG;
				sum_q[a] <= '0;
			end
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (take) begin
			if (full) begin
				// A full cluster ignores the point and only remembers the loss.
				drop_q <= 1'b1;
			end else begin
				for (int a = 0; a < NUM_AXES; a++) begin
					if ($signed(coord[a]) < $signed(min_q[a])) begin
						min_q[a] <= coord[a];
					end
					if ($signed(coord[a]) > $signed(max_q[a])) begin
						max_q[a] <= coord[a];
					end
					sum_q[a] <= sum_q[a] + SUM_W'($signed(coord[a]));
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign run_min   = min_q;
	assign run_max   = max_q;
	assign run_sum   = sum_q;
	assign run_count = cnt_q;
	assign drop_flag = drop_q;
endmodule

/* rtl/pcb_divider.sv */
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
module pcb_divider #(
	parameter int COORD_BITS = 24,
	parameter int CNT_W      = 17,
	parameter int SUM_W      = 41
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_W-1:0]      dividend,
	input  logic [CNT_W-1:0]      divisor,
	output logic                  done,
	output logic [COORD_BITS-1:0] quotient
);
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              fits;
	logic [COORD_BITS-1:0] mag;

	// The dividend register shifts out its top bit into the partial
	// remainder and takes the new quotient bit in at the bottom.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign mag      = quo_q[COORD_BITS-1:0];
	assign quotient = neg_q ? (~mag + 1'b1) : mag;
	assign done     = done_q;
endmodule

/* rtl/point_cluster_bbox_centroid_core.sv */
// Top level: cluster point intake, divide sequencer and result register.
// Points of a cluster are taken one per cycle, each updating the registered running
// per-axis minimum, maximum and sum and the point count as it is taken.
// When the point marked last is taken, the input stops accepting while one
// shared restoring divider forms the three centroid coordinates in turn, one
// quotient bit per cycle over the SUM_W dividend bits, where
// SUM_W = COORD_BITS + clog2(MAX_POINTS + 1). The last point holds the input
// through the three divisions and for as long as the previous result still
// waits in the output register. The finished box then moves into the output
// register and the input reopens at once, even while that result still waits
// to be taken. Points that arrive after MAX_POINTS points are dropped and the
// result reports this in overflowed.
// The result channel must be built with COUNT_BITS = clog2(MAX_POINTS + 1).
module point_cluster_bbox_centroid_core #(
	parameter int MAX_POINTS = 65536,
	parameter int COORD_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	pcb_point_if.sink     pts,
	pcb_result_if.source  box
);
	import pcb_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = COORD_BITS + CNT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0] state_q;
	axis_t      axis_q;

	logic [NUM_AXES-1:0][COORD_BITS-1:0] coord;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] acc_min;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] acc_max;
	logic [NUM_AXES-1:0][SUM_W-1:0]      acc_sum;
	logic [CNT_W-1:0]                    acc_count;
	logic                                acc_drop;
	logic                                accept;
	logic                                out_free;
	logic                                load;

	logic                                div_start;
	logic                                div_done;
	logic [COORD_BITS-1:0]               div_quo;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] mean_q;

	logic                                res_valid_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] res_min_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] res_max_q;
	logic [NUM_AXES-1:0][COORD_BITS-1:0] res_mean_q;
	logic [CNT_W-1:0]                    res_count_q;
	logic                                res_drop_q;

	assign coord[AXIS_X] = pts.coord_x;
	assign coord[AXIS_Y] = pts.coord_y;
	assign coord[AXIS_Z] = pts.coord_z;

	assign pts.ready = (state_q == ST_IDLE);
	assign accept    = pts.valid && pts.ready;
	assign out_free  = !res_valid_q || box.ready;
	assign load      = (state_q == ST_HOLD) && out_free;
	assign div_start = (state_q == ST_START);

	pcb_accum #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (load),
		.take      (accept),
		.coord     (coord),
		.run_min   (acc_min),
		.run_max   (acc_max),
		.run_sum   (acc_sum),
		.run_count (acc_count),
		.drop_flag (acc_drop)
	);

	pcb_divider #(
		.COORD_BITS (COORD_BITS),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_sum[axis_q]),
		.divisor  (acc_count),
		.done     (div_done),
		.quotient (div_quo)
	);

	// The accumulator keeps the finished cluster until its box is loaded
	// into the output register, so no separate snapshot is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && pts.last_point) begin
						state_q <= ST_START;
						axis_q  <= AXIS_X;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (axis_q == AXIS_Z) begin
							state_q <= ST_HOLD;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_done) begin
			mean_q[axis_q] <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (box.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_min_q   <= acc_min;
			res_max_q   <= acc_max;
			res_mean_q  <= mean_q;
			res_count_q <= acc_count;
			res_drop_q  <= acc_drop;
		end
	end

	assign box.valid       = res_valid_q;
	assign box.low_x       = res_min_q[AXIS_X];
	assign box.low_y       = res_min_q[AXIS_Y];
	assign box.low_z       = res_min_q[AXIS_Z];
	assign box.high_x      = res_max_q[AXIS_X];
	assign box.high_y      = res_max_q[AXIS_Y];
	assign box.high_z      = res_max_q[AXIS_Z];
	assign box.mean_x      = res_mean_q[AXIS_X];
	assign box.mean_y      = res_mean_q[AXIS_Y];
	assign box.mean_z      = res_mean_q[AXIS_Z];
	assign box.points_seen = res_count_q;
	assign box.overflowed  = res_drop_q;
endmodule

/* test/point_cluster_bbox_centroid_checker.sv */
// Passive checker: predicts each cluster box from the accepted points and compares it.
module point_cluster_bbox_centroid_checker #(
	parameter int MAX_POINTS = 65536,
	parameter int COORD_BITS = 24,
	parameter int COUNT_BITS = 17
) (
	input  logic  clk,
	input  logic  arst_n,
	pcb_point_if  pts,
	pcb_result_if box,
	output int    err_count,
	output int    boxes_pending
);
	import pcb_pkg::*;

	localparam int SUM_BITS = COORD_BITS + COUNT_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef struct packed {
		coord_t [NUM_AXES-1:0] low;
		coord_t [NUM_AXES-1:0] high;
		coord_t [NUM_AXES-1:0] mean;
		logic [COUNT_BITS-1:0] seen;
		logic                  ovf;
	} cluster_box_t;

	coord_t       lo_track [NUM_AXES];
	coord_t       hi_track [NUM_AXES];
	sum_t         sum_track [NUM_AXES];
	int           held;
	logic         dropped;
	cluster_box_t boxes_due [$];
	int           boxes_seen = 0;
	int           errors = 0;

	assign err_count = errors;
	assign boxes_pending = boxes_due.size();

	task automatic report_error(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string field, input logic [63:0] got_v, want_v);
		if (got_v !== want_v)
			report_error($sformatf("box %0d %s: got %0h, expected %0h",
				boxes_seen, field, got_v, want_v));
	endtask

	task automatic clear_tracks();
		for (int a = 0; a < NUM_AXES; a++) begin
			lo_track[a] = COORD_MAX;
			hi_track[a] = COORD_MIN;
			sum_track[a] = '0;
		end
		held = 0;
		dropped = 1'b0;
	endtask

	// Folds one point into the running box; on the last point the box is queued.
	task automatic take_point(input coord_t px, py, pz, input logic last);
		coord_t       c [NUM_AXES];
		cluster_box_t want;
		c[AXIS_X] = px;
		c[AXIS_Y] = py;
		c[AXIS_Z] = pz;
		if (held < MAX_POINTS) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (c[a] < lo_track[a])
					lo_track[a] = c[a];
				if (c[a] > hi_track[a])
					hi_track[a] = c[a];
				sum_track[a] = sum_track[a] + c[a];
			end
			held++;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				want.low[a] = lo_track[a];
				want.high[a] = hi_track[a];
				// Signed division truncates toward zero.
				want.mean[a] = coord_t'(longint'(sum_track[a]) / longint'(held));
			end
			want.seen = COUNT_BITS'(held);
			want.ovf = dropped;
			boxes_due.push_back(want);
			clear_tracks();
		end
	endtask

	task automatic check_box();
		cluster_box_t got;
		cluster_box_t want;
		got.low[AXIS_X] = box.low_x;
		got.low[AXIS_Y] = box.low_y;
		got.low[AXIS_Z] = box.low_z;
		got.high[AXIS_X] = box.high_x;
		got.high[AXIS_Y] = box.high_y;
		got.high[AXIS_Z] = box.high_z;
		got.mean[AXIS_X] = box.mean_x;
		got.mean[AXIS_Y] = box.mean_y;
		got.mean[AXIS_Z] = box.mean_z;
		got.seen = box.points_seen;
		got.ovf = box.overflowed;
		if (boxes_due.size() == 0) begin
			report_error($sformatf("box %0d arrived with no cluster closed", boxes_seen));
		end else begin
			want = boxes_due.pop_front();
			for (int a = 0; a < NUM_AXES; a++) begin
				check_field($sformatf("low[%0d]", a), {got.low[a]}, {want.low[a]});
				check_field($sformatf("high[%0d]", a), {got.high[a]}, {want.high[a]});
				check_field($sformatf("mean[%0d]", a), {got.mean[a]}, {want.mean[a]});
			end
			check_field("points_seen", {got.seen}, {want.seen});
			check_field("overflowed", {got.ovf}, {want.ovf});
		end
		boxes_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tracks();
			boxes_due.delete();
		end else begin
			if (pts.valid && pts.ready)
				take_point(pts.coord_x, pts.coord_y, pts.coord_z, pts.last_point);
			if (box.valid && box.ready)
				check_box();
		end
	end

endmodule

/* test/point_cluster_bbox_centroid_core_tb.sv */
// Testbench top: clock, reset, point stimulus, result back-pressure and verdict.
module point_cluster_bbox_centroid_core_tb;

	localparam int MAX_POINTS = 65536;
	localparam int COORD_BITS = 24;
	localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);
	localparam int RANDOM_POINTS = 1800;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	int   err_count;
	int   boxes_pending;
	int   quiet_cycles = 0;
	bit   calm;

	pcb_point_if #(.COORD_BITS(COORD_BITS)) pts ();
	pcb_result_if #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) box ();

	point_cluster_bbox_centroid_core #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pts   (pts),
		.box   (box)
	);

	point_cluster_bbox_centroid_checker #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.pts          (pts),
		.box          (box),
		.err_count    (err_count),
		.boxes_pending(boxes_pending)
	);

	always #6 clk = ~clk;

	always @(negedge clk)
		box.ready <= calm || ($urandom_range(0, 99) >= 15);

	// Ends the run when neither channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (pts.valid && pts.ready) || (box.valid && box.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_point(input coord_t x, y, z, input logic last);
		while (!calm && $urandom_range(0, 99) < 15) begin
			pts.valid <= 1'b0;
			@(negedge clk);
		end
		pts.valid <= 1'b1;
		pts.coord_x <= x;
		pts.coord_y <= y;
		pts.coord_z <= z;
		pts.last_point <= last;
		@(posedge clk);
		while (!pts.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Half the points scattered around the cluster center, the rest extremes and wide noise.
	function automatic coord_t rand_coord(input coord_t centre);
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3, 4: return coord_t'($urandom);
			default: return centre + coord_t'($urandom_range(0, 1023)) - coord_t'(512);
		endcase
	endfunction

	task automatic send_cluster(input int n);
		coord_t cx, cy, cz;
		cx = coord_t'($urandom);
		cy = coord_t'($urandom);
		cz = coord_t'($urandom);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(cx), rand_coord(cy), rand_coord(cz), i == n - 1);
	endtask

	initial begin
		int sent;
		int n;
		arst_n = 1'b0;
		calm = 1'b0;
		pts.valid = 1'b0;
		pts.coord_x = '0;
		pts.coord_y = '0;
		pts.coord_z = '0;
		pts.last_point = 1'b0;
		box.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-point clusters with x and y at the coordinate extremes.
		send_point(COORD_MAX, COORD_MIN, -1, 1'b1);
		send_point(COORD_MIN, COORD_MAX, 0, 1'b1);
		// Opposite extremes: the mean of -1/2 truncates to zero.
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		// Negative sums, of which only the z sum does not divide evenly.
		send_point(-1, -2, -3, 1'b0);
		send_point(-1, -1, -1, 1'b0);
		send_point(-1, 0, 0, 1'b1);
		// Positive sums, of which the x and z sums do not divide evenly.
		send_point(1, 2, 3, 1'b0);
		send_point(2, 2, 4, 1'b1);
		// Alternating bit patterns.
		send_point(coord_t'(24'hAAAAAA), coord_t'(24'h555555), coord_t'(24'hAAAAAA), 1'b0);
		send_point(coord_t'(24'h555555), coord_t'(24'hAAAAAA), coord_t'(24'h555555), 1'b1);

		sent = 0;
		while (sent < RANDOM_POINTS) begin
			calm = sent >= 600 && sent < 900;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			send_cluster(n);
			sent += n;
		end
		calm = 1'b0;

		send_cluster(3);

		pts.valid <= 1'b0;
		do
			@(negedge clk);
		while (boxes_pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0 && boxes_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/pcb_pkg.sv
rtl/pcb_point_if.sv
rtl/pcb_result_if.sv
rtl/pcb_accum.sv
rtl/pcb_divider.sv
rtl/point_cluster_bbox_centroid_core.sv
test/point_cluster_bbox_centroid_checker.sv
test/point_cluster_bbox_centroid_core_tb.sv
